FILE: rtl/two_resource_lock_scheduler_defines.svh
// ---------------------------------------------------------------------------
// two_resource_lock_scheduler defines
// assertion helpers shared by the scheduler rtl, clocked on clock and
// disabled while reset is high
// ---------------------------------------------------------------------------
`ifndef TWO_RESOURCE_LOCK_SCHEDULER_DEFINES_SVH
`define TWO_RESOURCE_LOCK_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define TRLS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("trls assertion failed");

// next-cycle implication
`define TRLS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("trls assertion failed");

// condition that must never hold
`define TRLS_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("trls assertion failed");

`endif

FILE: rtl/trls_pkg.sv
// ---------------------------------------------------------------------------
// trls_pkg
// types and codes shared by the two resource lock scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package trls_pkg;

   localparam int ID_W   = 8;
   localparam int TIME_W = 4;

   // command codes
   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // resource codes
   localparam logic RES_PRINTER = 1'b0;
   localparam logic RES_SCREEN  = 1'b1;

   // one pool entry
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TIME_W-1:0] run_time;
      logic              res;
   } trls_entry_type;

endpackage

`default_nettype wire

FILE: rtl/trls_job_mem.sv
// ---------------------------------------------------------------------------
// trls_job_mem
// job pool storage: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module trls_job_mem #(
   parameter int DEPTH = 16
) (
   input  wire logic                          clock,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire trls_pkg::trls_entry_type      wr_data,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output      trls_pkg::trls_entry_type      rd_data
);

   trls_pkg::trls_entry_type mem_ff [DEPTH];
   trls_pkg::trls_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/two_resource_lock_scheduler.sv
// ---------------------------------------------------------------------------
// two_resource_lock_scheduler
// lifo job pool with a printer lock and a screen lock, stepped by ticks
// ---------------------------------------------------------------------------
// usage
//  - input beat: req_command, req_job_time, req_job_resource, taken on a
//    rising edge with start high and busy low
//  - result beat: every input beat gives exactly one result, shown on the
//    rsp_ ports for one cycle with rsp_valid high; the receiver cannot stall,
//    so results are simply dropped onto the ports
//  - push: result in the cycle after the beat, busy stays low
//  - tick: busy while the sequencer works through the job memory: a lock
//    scan (skipped when both are locked or the pool is empty), a run of each
//    holder, and compaction of the entries above store index r when a holder
//    finishes at r; all of it goes through the single read port of the memory
//  - reset: synchronous, clears count, id counter, locks and strobe; the
//    job memory itself is not cleared, only entries below count are read
// ---------------------------------------------------------------------------
`default_nettype none
`include "two_resource_lock_scheduler_defines.svh"

module two_resource_lock_scheduler #(
   parameter int POOL_DEPTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // command channel
   input  wire logic                              start,
   output      logic                              busy,
   input  wire logic                              req_command,
   input  wire logic [trls_pkg::TIME_W-1:0]       req_job_time,
   input  wire logic                              req_job_resource,
   // result channel
   output      logic                              rsp_valid,
   output      logic                              rsp_push_accepted,
   output      logic [trls_pkg::ID_W-1:0]         rsp_job_id,
   output      logic                              rsp_printer_busy,
   output      logic                              rsp_screen_busy,
   output      logic                              rsp_printer_done,
   output      logic [trls_pkg::ID_W-1:0]         rsp_printer_done_id,
   output      logic                              rsp_screen_done,
   output      logic [trls_pkg::ID_W-1:0]         rsp_screen_done_id,
   output      logic [$clog2(POOL_DEPTH+1)-1:0]   rsp_pool_count
);

   localparam int CNT_W = $clog2(POOL_DEPTH + 1);
   localparam int IDX_W = $clog2(POOL_DEPTH);
   localparam int ID_W  = trls_pkg::ID_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RUN_RD,
      ST_RUN_CHK,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   // sequencer state
   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [ID_W-1:0]       next_id_ff, next_id_in;
   logic                  scr_lock_ff, scr_lock_in;
   logic [IDX_W-1:0]      scr_idx_ff, scr_idx_in;
   logic                  prn_lock_ff, prn_lock_in;
   logic [IDX_W-1:0]      prn_idx_ff, prn_idx_in;
   logic                  cur_scr_ff, cur_scr_in;   // holder being run
   logic [CNT_W-1:0]      ptr_ff, ptr_in;           // scan / shift read pointer
   logic [IDX_W-1:0]      tag_ff, tag_in;           // address of data in flight
   logic                  pend_ff, pend_in;         // read data arrives this cycle
   logic                  scr_done_ff, scr_done_in;
   logic [ID_W-1:0]       scr_done_id_ff, scr_done_id_in;
   logic                  prn_done_ff, prn_done_in;
   logic [ID_W-1:0]       prn_done_id_ff, prn_done_id_in;

   // registered result
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_acc_ff, rsp_acc_in;
   logic [ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                  rsp_pbusy_ff, rsp_pbusy_in;
   logic                  rsp_sbusy_ff, rsp_sbusy_in;
   logic                  rsp_pdone_ff, rsp_pdone_in;
   logic [ID_W-1:0]       rsp_pdone_id_ff, rsp_pdone_id_in;
   logic                  rsp_sdone_ff, rsp_sdone_in;
   logic [ID_W-1:0]       rsp_sdone_id_ff, rsp_sdone_id_in;
   logic [CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // memory port
   logic                       mem_we;
   logic [IDX_W-1:0]           mem_waddr;
   trls_pkg::trls_entry_type   mem_wdata;
   logic                       mem_re;
   logic [IDX_W-1:0]           mem_raddr;
   trls_pkg::trls_entry_type   mem_rdata;

   trls_job_mem #(
      .DEPTH (POOL_DEPTH)
   ) u_job_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      logic                          push_ok;
      logic                          adv;
      logic                          cur_lock;
      logic [IDX_W-1:0]              cur_idx;
      logic [CNT_W-1:0]              ptr_m1;
      logic [trls_pkg::TIME_W-1:0]   new_time;

      state_in        = state_ff;
      count_in        = count_ff;
      next_id_in      = next_id_ff;
      scr_lock_in     = scr_lock_ff;
      scr_idx_in      = scr_idx_ff;
      prn_lock_in     = prn_lock_ff;
      prn_idx_in      = prn_idx_ff;
      cur_scr_in      = cur_scr_ff;
      ptr_in          = ptr_ff;
      tag_in          = tag_ff;
      pend_in         = pend_ff;
      scr_done_in     = scr_done_ff;
      scr_done_id_in  = scr_done_id_ff;
      prn_done_in     = prn_done_ff;
      prn_done_id_in  = prn_done_id_ff;

      rsp_valid_in    = 1'b0;
      rsp_acc_in      = rsp_acc_ff;
      rsp_id_in       = rsp_id_ff;
      rsp_pbusy_in    = rsp_pbusy_ff;
      rsp_sbusy_in    = rsp_sbusy_ff;
      rsp_pdone_in    = rsp_pdone_ff;
      rsp_pdone_id_in = rsp_pdone_id_ff;
      rsp_sdone_in    = rsp_sdone_ff;
      rsp_sdone_id_in = rsp_sdone_id_ff;
      rsp_count_in    = rsp_count_ff;

      mem_we    = 1'b0;
      mem_waddr = tag_ff;
      mem_wdata = mem_rdata;
      mem_re    = 1'b0;
      mem_raddr = '0;

      adv      = 1'b0;
      push_ok  = (count_ff < CNT_W'(POOL_DEPTH)) && (req_job_time != '0);
      cur_lock = cur_scr_ff ? scr_lock_ff : prn_lock_ff;
      cur_idx  = cur_scr_ff ? scr_idx_ff : prn_idx_ff;
      ptr_m1   = ptr_ff - 1'b1;
      new_time = (mem_rdata.run_time != '0) ? mem_rdata.run_time - 1'b1 : '0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_command == trls_pkg::CMD_PUSH) begin
                  // push writes the newest entry at count
                  rsp_valid_in    = 1'b1;
                  rsp_acc_in      = push_ok;
                  rsp_id_in       = push_ok ? next_id_ff : '0;
                  rsp_pbusy_in    = prn_lock_ff;
                  rsp_sbusy_in    = scr_lock_ff;
                  rsp_pdone_in    = 1'b0;
                  rsp_pdone_id_in = '0;
                  rsp_sdone_in    = 1'b0;
                  rsp_sdone_id_in = '0;
                  rsp_count_in    = push_ok ? count_ff + 1'b1 : count_ff;
                  if (push_ok) begin
                     mem_we             = 1'b1;
                     mem_waddr          = count_ff[IDX_W-1:0];
                     mem_wdata.id       = next_id_ff;
                     mem_wdata.run_time = req_job_time;
                     mem_wdata.res      = req_job_resource;
                     count_in           = count_ff + 1'b1;
                     next_id_in         = next_id_ff + 1'b1;
                  end
               end else begin
                  scr_done_in    = 1'b0;
                  scr_done_id_in = '0;
                  prn_done_in    = 1'b0;
                  prn_done_id_in = '0;
                  cur_scr_in     = 1'b1;
                  ptr_in         = count_ff;
                  pend_in        = 1'b0;
                  if ((count_ff == '0) || (scr_lock_ff && prn_lock_ff)) begin
                     state_in = ST_RUN_RD;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end

         ST_SCAN: begin
            // newest-first scan, first match per free resource wins
            if (pend_ff) begin
               if (mem_rdata.res == trls_pkg::RES_SCREEN && !scr_lock_ff) begin
                  scr_lock_in = 1'b1;
                  scr_idx_in  = tag_ff;
               end
               if (mem_rdata.res == trls_pkg::RES_PRINTER && !prn_lock_ff) begin
                  prn_lock_in = 1'b1;
                  prn_idx_in  = tag_ff;
               end
            end
            if (ptr_ff != '0) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_m1[IDX_W-1:0];
               tag_in    = ptr_m1[IDX_W-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_m1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = ST_RUN_RD;
               end
            end
         end

         ST_RUN_RD: begin
            if (cur_lock && (CNT_W'(cur_idx) < count_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = cur_idx;
               state_in  = ST_RUN_CHK;
            end else begin
               adv = 1'b1;
            end
         end

         ST_RUN_CHK: begin
            if (new_time == '0) begin
               // holder finished: unlock, fix the other index, compact
               if (cur_scr_ff) begin
                  scr_done_in    = 1'b1;
                  scr_done_id_in = mem_rdata.id;
                  scr_lock_in    = 1'b0;
                  scr_idx_in     = '0;
                  if (prn_lock_ff && (prn_idx_ff > scr_idx_ff)) begin
                     prn_idx_in = prn_idx_ff - 1'b1;
                  end
               end else begin
                  prn_done_in    = 1'b1;
                  prn_done_id_in = mem_rdata.id;
                  prn_lock_in    = 1'b0;
                  prn_idx_in     = '0;
                  if (scr_lock_ff && (scr_idx_ff > prn_idx_ff)) begin
                     scr_idx_in = scr_idx_ff - 1'b1;
                  end
               end
               count_in = count_ff - 1'b1;
               ptr_in   = CNT_W'(cur_idx) + 1'b1;
               pend_in  = 1'b0;
               state_in = ST_SHIFT;
            end else begin
               mem_we             = 1'b1;
               mem_waddr          = cur_idx;
               mem_wdata.run_time = new_time;
               adv                = 1'b1;
            end
         end

         ST_SHIFT: begin
            // read k+1 ahead, write it to k in the next cycle
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = tag_ff;
               mem_wdata = mem_rdata;
            end
            if (ptr_ff <= count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = ptr_ff[IDX_W-1:0];
               tag_in    = ptr_m1[IDX_W-1:0];
               pend_in   = 1'b1;
               ptr_in    = ptr_ff + 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  adv = 1'b1;
               end
            end
         end

         ST_FINISH: begin
            rsp_valid_in    = 1'b1;
            rsp_acc_in      = 1'b0;
            rsp_id_in       = '0;
            rsp_pbusy_in    = prn_lock_ff;
            rsp_sbusy_in    = scr_lock_ff;
            rsp_pdone_in    = prn_done_ff;
            rsp_pdone_id_in = prn_done_id_ff;
            rsp_sdone_in    = scr_done_ff;
            rsp_sdone_id_in = scr_done_id_ff;
            rsp_count_in    = count_ff;
            state_in        = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // screen holder runs first, then the printer holder
      if (adv) begin
         if (cur_scr_ff) begin
            cur_scr_in = 1'b0;
            state_in   = ST_RUN_RD;
         end else begin
            state_in = ST_FINISH;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         next_id_ff   <= '0;
         scr_lock_ff  <= 1'b0;
         scr_idx_ff   <= '0;
         prn_lock_ff  <= 1'b0;
         prn_idx_ff   <= '0;
         cur_scr_ff   <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_id_ff   <= next_id_in;
         scr_lock_ff  <= scr_lock_in;
         scr_idx_ff   <= scr_idx_in;
         prn_lock_ff  <= prn_lock_in;
         prn_idx_ff   <= prn_idx_in;
         cur_scr_ff   <= cur_scr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff          <= ptr_in;
      tag_ff          <= tag_in;
      scr_done_ff     <= scr_done_in;
      scr_done_id_ff  <= scr_done_id_in;
      prn_done_ff     <= prn_done_in;
      prn_done_id_ff  <= prn_done_id_in;
      rsp_acc_ff      <= rsp_acc_in;
      rsp_id_ff       <= rsp_id_in;
      rsp_pbusy_ff    <= rsp_pbusy_in;
      rsp_sbusy_ff    <= rsp_sbusy_in;
      rsp_pdone_ff    <= rsp_pdone_in;
      rsp_pdone_id_ff <= rsp_pdone_id_in;
      rsp_sdone_ff    <= rsp_sdone_in;
      rsp_sdone_id_ff <= rsp_sdone_id_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign busy                = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_push_accepted   = rsp_acc_ff;
   assign rsp_job_id          = rsp_id_ff;
   assign rsp_printer_busy    = rsp_pbusy_ff;
   assign rsp_screen_busy     = rsp_sbusy_ff;
   assign rsp_printer_done    = rsp_pdone_ff;
   assign rsp_printer_done_id = rsp_pdone_id_ff;
   assign rsp_screen_done     = rsp_sdone_ff;
   assign rsp_screen_done_id  = rsp_sdone_id_ff;
   assign rsp_pool_count      = rsp_count_ff;

   // read and write of the same entry never overlap in one cycle
   `TRLS_ASSERT_NEVER(a_mem_collision, mem_we && mem_re && (mem_waddr == mem_raddr))
   // the two locks never point at the same entry
   `TRLS_ASSERT_NEVER(a_lock_shared, scr_lock_ff && prn_lock_ff && (scr_idx_ff == prn_idx_ff))
   // a held entry always lies inside the pool
   `TRLS_ASSERT_IMP(a_scr_idx_in_pool, scr_lock_ff, CNT_W'(scr_idx_ff) < count_ff)
   `TRLS_ASSERT_IMP(a_prn_idx_in_pool, prn_lock_ff, CNT_W'(prn_idx_ff) < count_ff)
   // a tick beat always starts the sequencer
   `TRLS_ASSERT_NXT(a_tick_goes_busy, start && !busy && (req_command == trls_pkg::CMD_TICK), busy)

endmodule

`default_nettype wire
